FILE: rtl/longest_increasing_run_length_unit_assert.svh
// Assertion macros for the longest increasing run length unit.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef LONGEST_INCREASING_RUN_LENGTH_UNIT_ASSERT_SVH
`define LONGEST_INCREASING_RUN_LENGTH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LIRL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LIRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lirl_pkg.sv
// Shared types and constants for the longest increasing run length unit.
// No dependencies.
`default_nettype none

package lirl_pkg;

  // Width of the reported run length.
  localparam int LEN_W = 11;

  typedef logic [LEN_W-1:0] len_t;

endpackage

`default_nettype wire

FILE: rtl/lirl_if.sv
// Request and result channel interfaces (valid/ready) of the run length unit.
// Depends on lirl_pkg.
`default_nettype none

interface lirl_in_if #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface lirl_out_if import lirl_pkg::*; ();
  logic valid;
  logic ready;
  len_t length;
  logic overflow;
  logic last_res;

  modport source (output valid, output length, output overflow, output last_res,
                  input ready);
  modport sink   (input valid, input length, input overflow, input last_res,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/longest_increasing_run_length_unit.sv
// Top level of the longest increasing run length unit.
// Depends on lirl_pkg, lirl_if (lirl_in_if, lirl_out_if) and lirl_tail_mem.
`default_nettype none

// Streams signed values and reports, for each one, the length of the longest
// strictly increasing subsequence seen so far (patience sorting with a sorted
// table of smallest tails in a single-port-read memory). One request is worked
// on at a time and the request side is not ready while it is in progress.
// An empty table takes the value straight in; otherwise the last tail is read
// and compared, and the value extends the table (or is dropped because the
// table is full) or replaces a tail found by a binary search over the table.
// Each probe of the binary search is one memory read and then one compare
// on the shared key comparator. A result may wait in the output register
// while the next request is accepted. A request marked last clears the length
// and the overflow flag after its result. No clearing pass is needed after
// reset.

module longest_increasing_run_length_unit import lirl_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  lirl_in_if.sink    in_ch,
  lirl_out_if.source out_ch
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_LAST,
    S_CMP_LAST,
    S_PROBE,
    S_CMP,
    S_FINISH
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic                   last_r, last_nxt;
  logic [AW-1:0]          lo_r, lo_nxt;
  logic [AW-1:0]          hi_r, hi_nxt;
  logic [AW-1:0]          mid_r, mid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  len_t                   out_len_r, out_len_nxt;
  logic                   out_ovf_r, out_ovf_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   in_fire;
  logic [VALUE_WIDTH-1:0] in_key;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   tail_lt_key;
  logic [AW-1:0]          mid;

  // Keys are order preserving unsigned forms of the values (sign bit flipped).
  assign in_key  = {~in_ch.value[VALUE_WIDTH-1], in_ch.value[VALUE_WIDTH-2:0]};
  assign in_fire = in_ch.valid && in_ch.ready;

  // Shared comparator: tail < key is also key > tail for the append test.
  assign tail_lt_key = rd_data < key_r;
  assign mid         = lo_r + ((hi_r - lo_r) >> 1);

  lirl_tail_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = lo_r;
    wr_data       = key_r;
    rd_en         = 1'b0;
    rd_addr       = mid;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt  = in_key;
          last_nxt = in_ch.last;
          if (count_r == '0) begin
            // Empty table: first tail goes straight in.
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = in_key;
            count_nxt = CW'(1);
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_READ_LAST;
          end
        end
      end
      S_READ_LAST: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(count_r - CW'(1));
        state_nxt = S_CMP_LAST;
      end
      S_CMP_LAST: begin
        if (tail_lt_key) begin
          if (count_r < CW'(TABLE_DEPTH)) begin
            wr_en     = 1'b1;
            wr_addr   = AW'(count_r);
            count_nxt = count_r + CW'(1);
          end else begin
            // Table full: drop the append, flag it.
            ovf_nxt = 1'b1;
          end
          state_nxt = S_FINISH;
        end else begin
          // Last tail is not less than the key, so the lower bound lies at or below it.
          lo_nxt    = '0;
          hi_nxt    = AW'(count_r - CW'(1));
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_r == hi_r) begin
          wr_en     = 1'b1;
          wr_addr   = lo_r;
          state_nxt = S_FINISH;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = mid;
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (tail_lt_key) begin
          lo_nxt = mid_r + AW'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_PROBE;
      end
      S_FINISH: begin
        // Hold until the result register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = LEN_W'(count_r);
          out_ovf_nxt   = ovf_r;
          out_last_nxt  = last_r;
          if (last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    last_r     <= last_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    out_len_r  <= out_len_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.length   = out_len_r;
  assign out_ch.overflow = out_ovf_r;
  assign out_ch.last_res = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/lirl_tail_mem.sv
// Tail key memory: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module lirl_tail_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lirl_checker.sv
// Port-level checks for the longest increasing run length unit, bound to it.
// Depends on lirl_pkg and longest_increasing_run_length_unit_assert.svh.
`default_nettype none

`include "longest_increasing_run_length_unit_assert.svh"

module lirl_checker import lirl_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire len_t length,
  input wire logic overflow,
  input wire logic last_res
);

  `LIRL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `LIRL_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(length) && $stable(overflow) && $stable(last_res), "stalled result changed")
  `LIRL_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready stayed high after a request")
  `LIRL_ASSERT_SAME(a_len_range, out_valid, 32'(length) <= 32'(TABLE_DEPTH), "length beyond table depth")
  `LIRL_ASSERT_SAME(a_ovf_full, out_valid && overflow, length == LEN_W'(TABLE_DEPTH), "overflow without a full table")

endmodule

bind longest_increasing_run_length_unit lirl_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_lirl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .length    (out_ch.length),
  .overflow  (out_ch.overflow),
  .last_res  (out_ch.last_res)
);

`default_nettype wire
